// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros for the rtl, used by sha256_byte_stream_hasher
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked at every rising edge, off while reset is asserted
`define SHA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: assertion failed");
// property checked at every rising edge, reset included
`define SHA_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("%m: assertion failed");
`else
`define SHA_ASSERT(lbl, clk, rst_n, prop)
`define SHA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== hw/rtl/sha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_pkg
// Types, constants and round functions of the SHA-256 byte stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

	typedef logic [31:0] word_t;
	// eight words, index 0 is a (or H0), index 7 is h (or H7)
	typedef logic [7:0][31:0] hash_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD_ONE,
		ST_PAD_ZERO,
		ST_PAD_LEN,
		ST_LOAD,
		ST_ROUND,
		ST_FINAL,
		ST_DIGEST
	} state_t;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam logic [5:0] BLOCK_LAST = 6'd63;
	localparam logic [5:0] ROUND_LAST = 6'd63;
	localparam logic [5:0] PRELOAD_LAST = 6'd15;
	localparam logic [2:0] WORD_LAST = 3'd7;

	localparam word_t HASH_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t rotr(word_t x, int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t big_sigma0(word_t x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_sigma1(word_t x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t small_sigma0(word_t x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_sigma1(word_t x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t choose(word_t e, word_t f, word_t g);
		return (e & f) ^ (~e & g);
	endfunction

	function automatic word_t majority(word_t a, word_t b, word_t c);
		return (a & b) ^ (a & c) ^ (b & c);
	endfunction

endpackage

// ===== hw/rtl/sha_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha stream interfaces
// Valid/ready channels for message bytes in and digest words out.
// ----------------------------------------------------------------------------
interface sha_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       end_of_message;

	modport source (output valid, data_byte, byte_present, end_of_message, input ready);
	modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha_digest_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== hw/rtl/sha_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_round
// One SHA-256 compression round on the working variables a..h.
// ----------------------------------------------------------------------------
module sha_round (
	input  sha_pkg::hash_t cur,
	input  sha_pkg::word_t kw,
	output sha_pkg::hash_t nxt
);
	import sha_pkg::*;

	word_t t1;
	word_t t2;

	// kw already holds round constant plus schedule word
	assign t1 = cur[7] + big_sigma1(cur[4]) + choose(cur[4], cur[5], cur[6]) + kw;
	assign t2 = big_sigma0(cur[0]) + majority(cur[0], cur[1], cur[2]);

	// rotate the variables, new a and new e
	assign nxt[0] = t1 + t2;
	assign nxt[1] = cur[0];
	assign nxt[2] = cur[1];
	assign nxt[3] = cur[2];
	assign nxt[4] = cur[3] + t1;
	assign nxt[5] = cur[4];
	assign nxt[6] = cur[5];
	assign nxt[7] = cur[6];

endmodule

// ===== hw/rtl/sha256_byte_stream_hasher.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 over a byte stream, one shared round unit under a small sequencer.
//
//   channel     dir  payload                                   transfer
//   byte_ch     in   data_byte, byte_present, end_of_message   valid & ready
//   digest_ch   out  digest_word, word_index, last_word        valid & ready
//
// A byte item is taken while the block is idle. The item that fills a block
// holds the input off through a load step, 64 rounds of the round unit and
// a hash update step. An end item pads one byte per cycle up to the
// next block end (plus a second block when the length does not fit), runs
// the compression per block, then offers the eight digest words, one per
// transfer, with the input held off until the last one is taken.
// Reset leaves the block idle with the initial hash values loaded.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
	input logic         clk,
	input logic         arst_n,
	sha_byte_if.sink    byte_ch,
	sha_digest_if.source digest_ch
);
	import sha_pkg::*;

	state_t      state_q;
	state_t      state_d;
	state_t      ret_q;
	state_t      ret_d;
	logic [5:0]  blk_q;
	logic [60:0] msg_q;
	logic [5:0]  rnd_q;
	logic [2:0]  idx_q;
	hash_t       hash_q;
	hash_t       work_q;
	hash_t       work_nxt;
	logic [511:0] sched_q;
	word_t       kw_q;

	logic        in_xfer;
	logic        out_xfer;
	logic        shift_en;
	logic [7:0]  shift_byte;
	logic        gen_en;
	logic [5:0]  gen_idx;
	word_t       w_new;
	logic [63:0] len_bits;
	logic [63:0] len_sh;

	assign in_xfer = byte_ch.valid && byte_ch.ready;
	assign out_xfer = digest_ch.valid && digest_ch.ready;

	// length field byte for the current pad position
	assign len_bits = {msg_q, 3'b000};
	assign len_sh = len_bits >> {WORD_LAST - blk_q[2:0], 3'b000};

	// next state
	always_comb begin
		state_d = state_q;
		ret_d = ret_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					if (byte_ch.byte_present && blk_q == BLOCK_LAST) begin
						state_d = ST_LOAD;
						ret_d = byte_ch.end_of_message ? ST_PAD_ONE : ST_IDLE;
					end else if (byte_ch.end_of_message) begin
						state_d = ST_PAD_ONE;
					end
				end
			end
			ST_PAD_ONE: begin
				if (blk_q == BLOCK_LAST) begin
					state_d = ST_LOAD;
					ret_d = ST_PAD_ZERO;
				end else begin
					state_d = ST_PAD_ZERO;
				end
			end
			ST_PAD_ZERO: begin
				if (blk_q == LEN_POS) begin
					state_d = ST_PAD_LEN;
				end else if (blk_q == BLOCK_LAST) begin
					state_d = ST_LOAD;
					ret_d = ST_PAD_ZERO;
				end
			end
			ST_PAD_LEN: begin
				if (blk_q == BLOCK_LAST) begin
					state_d = ST_LOAD;
					ret_d = ST_DIGEST;
				end
			end
			ST_LOAD: state_d = ST_ROUND;
			ST_ROUND: begin
				if (rnd_q == ROUND_LAST) state_d = ST_FINAL;
			end
			ST_FINAL: state_d = ret_q;
			ST_DIGEST: begin
				if (out_xfer && idx_q == WORD_LAST) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// handshake and datapath controls
	always_comb begin
		byte_ch.ready = 1'b0;
		digest_ch.valid = 1'b0;
		shift_en = 1'b0;
		shift_byte = byte_ch.data_byte;
		gen_en = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				byte_ch.ready = 1'b1;
				shift_en = in_xfer && byte_ch.byte_present;
			end
			ST_PAD_ONE: begin
				shift_en = 1'b1;
				shift_byte = PAD_MARK;
			end
			ST_PAD_ZERO: begin
				shift_en = (blk_q != LEN_POS);
				shift_byte = 8'h00;
			end
			ST_PAD_LEN: begin
				shift_en = 1'b1;
				shift_byte = len_sh[7:0];
			end
			ST_LOAD: gen_en = 1'b1;
			ST_ROUND: gen_en = (rnd_q != ROUND_LAST);
			ST_FINAL: ;
			ST_DIGEST: digest_ch.valid = 1'b1;
			default: ;
		endcase
	end

	// schedule step: block words first, then the recurrence over the taps
	assign gen_idx = (state_q == ST_LOAD) ? 6'd0 : rnd_q + 6'd1;
	always_comb begin
		if (state_q == ST_LOAD || rnd_q < PRELOAD_LAST) begin
			w_new = sched_q[511:480];
		end else begin
			w_new = sched_q[511:480] + small_sigma0(sched_q[479:448])
				+ sched_q[223:192] + small_sigma1(sched_q[63:32]);
		end
	end

	sha_round u_round (
		.cur (work_q),
		.kw  (kw_q),
		.nxt (work_nxt)
	);

	// sequencer state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q <= ST_IDLE;
			blk_q <= '0;
			msg_q <= '0;
			rnd_q <= '0;
			idx_q <= '0;
			for (int i = 0; i < 8; i++) hash_q[i] <= HASH_INIT[i];
		end else begin
			state_q <= state_d;
			ret_q <= ret_d;
			if (shift_en) blk_q <= blk_q + 6'd1;
			if (state_q == ST_IDLE && in_xfer && byte_ch.byte_present) begin
				msg_q <= msg_q + 61'd1;
			end
			if (state_q == ST_LOAD) begin
				rnd_q <= '0;
			end else if (state_q == ST_ROUND) begin
				rnd_q <= rnd_q + 6'd1;
			end
			// fold the working variables into the hash
			if (state_q == ST_FINAL) begin
				for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + work_q[i];
			end
			// digest words out, then restart the message
			if (out_xfer) begin
				idx_q <= idx_q + 3'd1;
				if (idx_q == WORD_LAST) begin
					msg_q <= '0;
					for (int i = 0; i < 8; i++) hash_q[i] <= HASH_INIT[i];
				end
			end
		end
	end

	// block bytes, message schedule and working variables
	always_ff @(posedge clk) begin
		if (shift_en) begin
			sched_q <= {sched_q[503:0], shift_byte};
		end else if (gen_en) begin
			sched_q <= {sched_q[479:0], w_new};
			kw_q <= w_new + ROUND_K[gen_idx];
		end
		if (state_q == ST_LOAD) begin
			work_q <= hash_q;
		end else if (state_q == ST_ROUND) begin
			work_q <= work_nxt;
		end
	end

	// digest output
	assign digest_ch.digest_word = hash_q[idx_q];
	assign digest_ch.word_index = idx_q;
	assign digest_ch.last_word = (idx_q == WORD_LAST);

	// checks
	`SHA_ASSERT_ALWAYS(a_no_overlap, clk, !(byte_ch.ready && digest_ch.valid))
	`SHA_ASSERT(a_idle_after_last, clk, arst_n, (out_xfer && digest_ch.last_word) |=> byte_ch.ready)
	`SHA_ASSERT(a_word_order, clk, arst_n, (out_xfer && !digest_ch.last_word) |=> (digest_ch.valid && digest_ch.word_index == $past(digest_ch.word_index) + 3'd1))
	`SHA_ASSERT(a_count_match, clk, arst_n, (state_q == ST_IDLE) |-> (blk_q == msg_q[5:0]))

endmodule
